@@ rtl/dynamic_tilt_envelope_detector_assert.svh @@
// Assertion macros used by the envelope detector controller RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef DYNAMIC_TILT_ENVELOPE_DETECTOR_ASSERT_SVH
`define DYNAMIC_TILT_ENVELOPE_DETECTOR_ASSERT_SVH

// Same-cycle implication.
`define DTD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtd: same-cycle check failed");

// Next-cycle implication.
`define DTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtd: next-cycle check failed");

`endif

@@ rtl/dtd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dtd_pkg;

    localparam int CHANNELS_DEF = 2;
    localparam int SAMPLE_W     = 16;
    localparam int ENV_W        = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int TILT_W       = 9;
    localparam int EDB_W        = 11;
    localparam int LOG_STEPS    = 16;

    // Register reset values.
    localparam logic               MODE_RESET    = 1'b0;
    localparam logic [15:0]        ATTACK_RESET  = 16'd65237;
    localparam logic [15:0]        RELEASE_RESET = 16'd65528;
    localparam logic signed [10:0] THR_RESET     = -11'sd240;
    localparam logic [6:0]         RANGE_RESET   = 7'd30;
    localparam logic signed [7:0]  BASE_RESET    = 8'sd0;

    // Arithmetic constants.
    localparam logic [ENV_W-1:0]   LEVEL_FLOOR   = 32'd1074;
    localparam logic [ENV_W-1:0]   SQRT_FLOOR    = 32'd11;
    localparam logic signed [23:0] DB_PER_OCTAVE = 24'sd3945660;
    localparam logic [12:0]        RECIP_240     = 13'd4369;
    localparam logic signed [15:0] EDB_MIN       = -16'sd1000;

    typedef enum logic [2:0] {
        REG_MODE      = 3'd0,
        REG_ATTACK    = 3'd1,
        REG_RELEASE   = 3'd2,
        REG_THRESHOLD = 3'd3,
        REG_RANGE     = 3'd4,
        REG_BASE_TILT = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_MUL1,
        S_MUL2,
        S_SQRT_INIT,
        S_SQRT,
        S_PEAK,
        S_LOG_INIT,
        S_NORM,
        S_LOG,
        S_DB_MUL,
        S_DB_ROUND,
        S_DYN_MUL,
        S_DYN_DIV,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SQUARE,
        OP_MUL1,
        OP_MUL2,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_PEAK,
        OP_LOG_INIT,
        OP_NORM,
        OP_LOG_STEP,
        OP_DB_MUL,
        OP_DB_ROUND,
        OP_DYN_MUL,
        OP_DYN_DIV,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic in_ch_ok;
        logic in_last;
        logic rms;
        logic last;
        logic sq_last;
        logic norm_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/dtd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dtd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               channel;
    logic               block_end;

    modport source (output valid, sample, channel, block_end, input ready);
    modport sink (input valid, sample, channel, block_end, output ready);
endinterface

interface dtd_out_if;
    logic               valid;
    logic               ready;
    logic signed [8:0]  total_tilt_db;
    logic signed [10:0] envelope_db;

    modport source (output valid, total_tilt_db, envelope_db, input ready);
    modport sink (input valid, total_tilt_db, envelope_db, output ready);
endinterface

`default_nettype wire

@@ rtl/dtd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "dynamic_tilt_envelope_detector_assert.svh"

module dtd_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire dtd_pkg::status_t status,
    output dtd_pkg::cmd_t        cmd
);
    import dtd_pkg::*;

    localparam int CNT_W = $clog2(LOG_STEPS);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (status.in_ch_ok)
                        state_next = status.rms ? S_SQUARE : S_MUL1;
                    else if (status.in_last)
                        state_next = S_LOG_INIT;
                end
            end
            S_SQUARE:    state_next = S_MUL1;
            S_MUL1:      state_next = S_MUL2;
            S_MUL2:      state_next = status.rms ? S_SQRT_INIT : S_PEAK;
            S_SQRT_INIT: state_next = S_SQRT;
            S_SQRT:
            begin
                if (status.sq_last)
                    state_next = S_PEAK;
            end
            S_PEAK:      state_next = status.last ? S_LOG_INIT : S_IDLE;
            S_LOG_INIT:  state_next = S_NORM;
            S_NORM:
            begin
                if (status.norm_done)
                begin
                    state_next = S_LOG;
                    cnt_next   = '0;
                end
            end
            S_LOG:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(LOG_STEPS - 1))
                    state_next = S_DB_MUL;
            end
            S_DB_MUL:    state_next = S_DB_ROUND;
            S_DB_ROUND:  state_next = S_DYN_MUL;
            S_DYN_MUL:   state_next = S_DYN_DIV;
            S_DYN_DIV:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == S_IDLE);
        cmd.load = accept;
        unique case (state_reg)
            S_SQUARE:    cmd.op = OP_SQUARE;
            S_MUL1:      cmd.op = OP_MUL1;
            S_MUL2:      cmd.op = OP_MUL2;
            S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
            S_SQRT:      cmd.op = OP_SQRT_STEP;
            S_PEAK:      cmd.op = OP_PEAK;
            S_LOG_INIT:  cmd.op = OP_LOG_INIT;
            S_NORM:      cmd.op = OP_NORM;
            S_LOG:       cmd.op = OP_LOG_STEP;
            S_DB_MUL:    cmd.op = OP_DB_MUL;
            S_DB_ROUND:  cmd.op = OP_DB_ROUND;
            S_DYN_MUL:   cmd.op = OP_DYN_MUL;
            S_DYN_DIV:   cmd.op = OP_DYN_DIV;
            S_EMIT:      cmd.op = status.out_free ? OP_EMIT : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

    `DTD_ASSERT_NEXT(a_busy_after_valid_channel, accept && status.in_ch_ok, state_reg != S_IDLE)
    `DTD_ASSERT_NEXT(a_log_loop_exit, state_reg == S_LOG && cnt_reg == CNT_W'(LOG_STEPS - 1), state_reg == S_DB_MUL)
    `DTD_ASSERT_NEXT(a_log_loop_start, state_reg == S_NORM && status.norm_done, state_reg == S_LOG && cnt_reg == '0)
    `DTD_ASSERT_IMPL(a_emit_needs_block_end, state_reg == S_EMIT, status.last)

endmodule

`default_nettype wire

@@ rtl/dtd_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dtd_datapath #(
    parameter int CHANNELS = dtd_pkg::CHANNELS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [dtd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dtd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic signed [dtd_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                             channel,
    input  wire logic                             block_end,
    output logic signed [dtd_pkg::TILT_W-1:0]     total_tilt_db,
    output logic signed [dtd_pkg::EDB_W-1:0]      envelope_db,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    input  wire dtd_pkg::cmd_t                    cmd,
    output dtd_pkg::status_t                      status
);
    import dtd_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration registers.
    logic               mode_reg;
    logic [15:0]        attack_reg;
    logic [15:0]        release_reg;
    logic signed [10:0] thr_reg;
    logic [6:0]         range_reg;
    logic signed [7:0]  base_reg;

    // Persistent state.
    logic [ENV_W-1:0]   env_mem_reg [CHANNELS];
    logic [ENV_W-1:0]   peak_reg;
    logic               out_valid_reg;

    // Working registers.
    logic [CH_W-1:0]    ch_reg;
    logic               last_reg;
    logic [ENV_W-1:0]   lvl_reg;
    logic [ENV_W-1:0]   env_reg;
    logic [47:0]        prod_reg;
    logic [16:0]        cw_reg;
    logic [63:0]        sq_x_reg;
    logic [63:0]        sq_res_reg;
    logic [63:0]        sq_bit_reg;
    logic [31:0]        y_reg;
    logic [4:0]         exp_reg;
    logic [15:0]        frac_reg;
    logic signed [47:0] db_prod_reg;
    logic signed [10:0] e_reg;
    logic signed [11:0] diff_reg;
    logic signed [19:0] num_reg;
    logic [14:0]        lim_reg;
    logic [14:0]        t_reg;
    logic [7:0]         qe_reg;
    logic               neg_reg;
    logic               sat_pos_reg;
    logic               sat_neg_reg;
    logic signed [8:0]  total_reg;
    logic signed [10:0] edb_reg;

    // Combinational helpers.
    logic               in_ch_ok;
    logic [16:0]        mag;
    logic [ENV_W-1:0]   lvl_new;
    logic [63:0]        lvl_sq;
    logic [15:0]        coef;
    logic [49:0]        acc;
    logic [ENV_W-1:0]   env_new;
    logic [ENV_W-1:0]   sq_in;
    logic [63:0]        sq_trial;
    logic [ENV_W-1:0]   peak_cand;
    logic [63:0]        y_sq;
    logic signed [5:0]  exp_off;
    logic signed [21:0] log2_val;
    logic [47:0]        db_abs;
    logic [47:0]        db_rnd;
    logic signed [15:0] e_full;
    logic signed [15:0] e_clamp;
    logic [19:0]        num_abs;
    logic [14:0]        t_new;
    logic [14:0]        rem;
    logic [7:0]         q_fix;
    logic signed [8:0]  dyn;

    assign in_ch_ok = ({31'b0, channel} < 32'(CHANNELS));
    assign mag      = sample[15] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
    assign lvl_new  = (32'(mag) << 15) + LEVEL_FLOOR;
    assign lvl_sq   = {32'b0, lvl_reg} * {32'b0, lvl_reg};
    assign coef     = (lvl_reg > env_reg) ? attack_reg : release_reg;
    assign acc      = {2'b0, prod_reg} + ({33'b0, cw_reg} * {18'b0, lvl_reg}) + 50'd32768;
    assign env_new  = acc[47:16];
    assign sq_in    = (env_reg < SQRT_FLOOR) ? SQRT_FLOOR : env_reg;
    assign sq_trial = sq_res_reg + sq_bit_reg;
    assign peak_cand = mode_reg ? sq_res_reg[31:0] : env_reg;
    assign y_sq     = {32'b0, y_reg} * {32'b0, y_reg};
    assign exp_off  = $signed({1'b0, exp_reg}) - 6'sd30;
    assign log2_val = $signed({exp_off, frac_reg});

    // Round half away from zero on the Q16 x Q16 product.
    assign db_abs   = db_prod_reg[47] ? 48'(-db_prod_reg) : 48'(db_prod_reg);
    assign db_rnd   = db_abs + 48'h0000_8000_0000;
    assign e_full   = db_prod_reg[47] ? -$signed(db_rnd[47:32]) : $signed(db_rnd[47:32]);
    assign e_clamp  = (e_full < EDB_MIN) ? EDB_MIN : ((e_full > 16'sd0) ? 16'sd0 : e_full);

    // Division by 240: reciprocal estimate, then one correction step.
    assign num_abs  = num_reg[19] ? 20'(-num_reg) : 20'(num_reg);
    assign t_new    = num_abs[14:0] + 15'd120;
    assign rem      = t_reg - ({7'b0, qe_reg} * 15'd240);
    assign q_fix    = (rem >= 15'd240) ? (qe_reg + 8'd1) : qe_reg;

    always_comb
    begin
        if (sat_pos_reg)
            dyn = $signed({2'b0, range_reg});
        else if (sat_neg_reg)
            dyn = -$signed({2'b0, range_reg});
        else if (neg_reg)
            dyn = -$signed({1'b0, q_fix});
        else
            dyn = $signed({1'b0, q_fix});
    end

    // Configuration, envelopes, block peak and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RESET;
            attack_reg    <= ATTACK_RESET;
            release_reg   <= RELEASE_RESET;
            thr_reg       <= THR_RESET;
            range_reg     <= RANGE_RESET;
            base_reg      <= BASE_RESET;
            for (int i = 0; i < CHANNELS; i++)
                env_mem_reg[i] <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MODE:      mode_reg    <= cfg_data[0];
                    REG_ATTACK:    attack_reg  <= cfg_data;
                    REG_RELEASE:   release_reg <= cfg_data;
                    REG_THRESHOLD: thr_reg     <= cfg_data[10:0];
                    REG_RANGE:     range_reg   <= cfg_data[6:0];
                    REG_BASE_TILT: base_reg    <= cfg_data[7:0];
                    default:       ;
                endcase
            end
            if (cmd.op == OP_MUL2)
                env_mem_reg[ch_reg] <= env_new;
            if (cmd.op == OP_PEAK && peak_cand > peak_reg)
                peak_reg <= peak_cand;
            if (cmd.op == OP_EMIT)
            begin
                peak_reg      <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg   <= CH_W'(channel);
            last_reg <= block_end;
            lvl_reg  <= lvl_new;
            if (in_ch_ok)
                env_reg <= env_mem_reg[CH_W'(channel)];
        end
        unique case (cmd.op)
            OP_SQUARE:    lvl_reg <= lvl_sq[61:30];
            OP_MUL1:
            begin
                prod_reg <= {32'b0, coef} * {16'b0, env_reg};
                cw_reg   <= 17'h10000 - {1'b0, coef};
            end
            OP_MUL2:      env_reg <= env_new;
            OP_SQRT_INIT:
            begin
                sq_x_reg   <= {2'b0, sq_in, 30'b0};
                sq_res_reg <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
            end
            OP_SQRT_STEP:
            begin
                if (sq_x_reg >= sq_trial)
                begin
                    sq_x_reg   <= sq_x_reg - sq_trial;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            OP_LOG_INIT:
            begin
                y_reg    <= (peak_reg < LEVEL_FLOOR) ? LEVEL_FLOOR : peak_reg;
                exp_reg  <= 5'd31;
                frac_reg <= '0;
            end
            OP_NORM:
            begin
                if (!y_reg[31])
                begin
                    y_reg   <= y_reg << 1;
                    exp_reg <= exp_reg - 5'd1;
                end
            end
            OP_LOG_STEP:
            begin
                if (y_sq[63])
                begin
                    frac_reg <= {frac_reg[14:0], 1'b1};
                    y_reg    <= y_sq[63:32];
                end
                else
                begin
                    frac_reg <= {frac_reg[14:0], 1'b0};
                    y_reg    <= y_sq[62:31];
                end
            end
            OP_DB_MUL:    db_prod_reg <= 48'(log2_val) * 48'(DB_PER_OCTAVE);
            OP_DB_ROUND:
            begin
                e_reg    <= e_clamp[10:0];
                diff_reg <= 12'(e_clamp) - 12'(thr_reg);
            end
            OP_DYN_MUL:
            begin
                num_reg <= 20'(diff_reg) * 20'($signed({1'b0, range_reg}));
                lim_reg <= {8'b0, range_reg} * 15'd240;
            end
            OP_DYN_DIV:
            begin
                sat_pos_reg <= (num_reg >= $signed({5'b0, lim_reg}));
                sat_neg_reg <= (num_reg <= -$signed({5'b0, lim_reg}));
                neg_reg     <= num_reg[19];
                t_reg       <= t_new;
                qe_reg      <= 8'(({13'b0, t_new} * {15'b0, RECIP_240}) >> 20);
            end
            OP_EMIT:
            begin
                total_reg <= 9'(base_reg) + dyn;
                edb_reg   <= e_reg;
            end
            default:      ;
        endcase
    end

    assign total_tilt_db = total_reg;
    assign envelope_db   = edb_reg;
    assign out_valid     = out_valid_reg;

    always_comb
    begin
        status.in_ch_ok  = in_ch_ok;
        status.in_last   = block_end;
        status.rms       = mode_reg;
        status.last      = last_reg;
        status.sq_last   = sq_bit_reg[0];
        status.norm_done = y_reg[31];
        status.out_free  = !out_valid_reg || out_ready;
    end

endmodule

`default_nettype wire

@@ rtl/dynamic_tilt_envelope_detector.sv @@
// Peak mode: each sample runs from acceptance to the next ready through load, two filter
// multiplies and peak compare. RMS mode adds the squaring multiply and the bit-serial
// square root, one result bit per cycle over 32 steps.
// A block-ending sample adds setup, normalization, a 16-step log2 squaring loop, dB
// and tilt math, plus any output wait.
// Reset clears all envelopes, the block peak and output valid; registers take defaults.
`timescale 1ns / 1ps
`default_nettype none

module dynamic_tilt_envelope_detector #(
    parameter int CHANNELS = dtd_pkg::CHANNELS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dtd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dtd_pkg::CFG_DATA_W-1:0] cfg_data,
    dtd_in_if.sink                              din,
    dtd_out_if.source                           dout
);
    import dtd_pkg::*;

    // The controller sequences one sample at a time: it takes a beat only in its
    // idle state, then steps the datapath through the filter update, the optional
    // square root, the peak update and, on a block end, the dB conversion.
    // Command and status travel as two structs between the two halves.
    cmd_t    cmd;
    status_t status;

    dtd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (din.valid),
        .in_ready (din.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the configuration registers, the per-channel envelope
    // store, the block peak, the iterative square root and log2 units and the
    // output register. A result beat waits in that register while the next
    // sample is already taken in; only a second block end stalls on it.
    dtd_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample        (din.sample),
        .channel       (din.channel),
        .block_end     (din.block_end),
        .total_tilt_db (dout.total_tilt_db),
        .envelope_db   (dout.envelope_db),
        .out_valid     (dout.valid),
        .out_ready     (dout.ready),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

`default_nettype wire
